// File: hw/rtl/assert_macros.svh
// shared assertion macros for the tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AHTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AHTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ahtt_pkg.sv
package ahtt_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int ADDR_BITS_DEF = 48;
    localparam int TXN_BITS_DEF  = 16;

    // slot index
    localparam int IDX_W = $clog2(CAPACITY_DEF);
    typedef logic [IDX_W-1:0] t_idx;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_FULL        = 2'd1,
        ERR_NOT_VALID   = 2'd2,
        ERR_NOT_GRANTED = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // record that walks the cell row one cell per cycle
    typedef struct packed {
        logic pulse;
        logic free_hit;
        t_idx free_idx;
        logic tail_hit;
        t_idx tail_idx;
        logic sel_valid;
        logic sel_granted;
        logic sel_has_succ;
        t_idx sel_succ;
    } t_carry;

    // table update broadcast to every cell
    typedef struct packed {
        logic wr_en;
        t_idx wr_idx;
        logic wr_granted;
        logic link_en;
        t_idx link_idx;
        t_idx link_succ;
        logic clr_en;
        t_idx clr_idx;
        logic grant_en;
        t_idx grant_idx;
    } t_cell_upd;

endpackage

// File: hw/rtl/ahtt_if.sv
interface ahtt_req_if #(
    parameter int ADDR_BITS = 48,
    parameter int TXN_BITS  = 16
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [TXN_BITS-1:0]  txn_id;
    logic [ADDR_BITS-1:0] address;
    logic [4:0]           slot;

    modport source (output valid, mode, txn_id, address, slot, input ready);
    modport sink   (input valid, mode, txn_id, address, slot, output ready);
endinterface

interface ahtt_rsp_if #(
    parameter int TXN_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [4:0]          alloc_slot;
    logic                grant_valid;
    logic [4:0]          grant_slot;
    logic [TXN_BITS-1:0] grant_txn_id;
    logic [1:0]          error_code;

    modport source (output valid, alloc_slot, grant_valid, grant_slot, grant_txn_id,
                    error_code, input ready);
    modport sink   (input valid, alloc_slot, grant_valid, grant_slot, grant_txn_id,
                    error_code, output ready);
endinterface

// File: hw/rtl/ahtt_cell.sv
module ahtt_cell
    import ahtt_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int TXN_BITS  = TXN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [TXN_BITS-1:0]  i_txn,
    input  t_idx                 i_sel,
    input  t_cell_upd            i_upd,
    input  t_carry               i_carry,
    input  logic [TXN_BITS-1:0]  i_carry_txn,
    output t_carry               o_carry,
    output logic [TXN_BITS-1:0]  o_carry_txn
);

    localparam t_idx ME = t_idx'(IDX);

    logic                 r_valid;
    logic                 r_granted;
    logic                 r_has_succ;
    t_idx                 r_succ;
    logic [TXN_BITS-1:0]  r_txn;
    logic [ADDR_BITS-1:0] r_addr;
    t_carry               r_carry;
    logic [TXN_BITS-1:0]  r_carry_txn;
    t_carry               n_carry;
    logic [TXN_BITS-1:0]  n_carry_txn;

    // fold this entry into the passing record
    always_comb begin
        n_carry     = i_carry;
        n_carry_txn = i_carry_txn;
        if (!i_carry.free_hit && !r_valid) begin
            n_carry.free_hit = 1'b1;
            n_carry.free_idx = ME;
        end
        if (!i_carry.tail_hit && r_valid && !r_has_succ && r_addr == i_addr) begin
            n_carry.tail_hit = 1'b1;
            n_carry.tail_idx = ME;
        end
        if (i_sel == ME) begin
            n_carry.sel_valid    = r_valid;
            n_carry.sel_granted  = r_granted;
            n_carry.sel_has_succ = r_has_succ;
            n_carry.sel_succ     = r_succ;
            n_carry_txn          = r_txn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
        r_carry_txn <= n_carry_txn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_granted  <= 1'b0;
            r_has_succ <= 1'b0;
        end else begin
            if (i_upd.wr_en && i_upd.wr_idx == ME) begin
                r_valid    <= 1'b1;
                r_granted  <= i_upd.wr_granted;
                r_has_succ <= 1'b0;
            end
            if (i_upd.link_en && i_upd.link_idx == ME) begin
                r_has_succ <= 1'b1;
            end
            if (i_upd.clr_en && i_upd.clr_idx == ME) begin
                r_valid    <= 1'b0;
                r_granted  <= 1'b0;
                r_has_succ <= 1'b0;
            end
            if (i_upd.grant_en && i_upd.grant_idx == ME) begin
                r_granted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.wr_en && i_upd.wr_idx == ME) begin
            r_txn  <= i_txn;
            r_addr <= i_addr;
        end
        if (i_upd.link_en && i_upd.link_idx == ME) begin
            r_succ <= i_upd.link_succ;
        end
    end

    assign o_carry     = r_carry;
    assign o_carry_txn = r_carry_txn;

endmodule

// File: hw/rtl/address_hazard_transaction_tracker.sv
// transaction tracker with same-address ordering
// i_req (sink): mode 0 allocates a slot for txn_id/address, mode 1 releases slot
// o_rsp (source): one response per request with alloc slot, grant and error code
// the table is a row of CAPACITY cells; each request sends one record down the
// row, one cell per cycle, collecting the lowest free slot, the chain tail for
// the address and the state of the addressed slot
// allocate and plain release walk the row once, then commit the response
// and the table update; the next request is taken after the commit
// release that hands over to a waiting entry walks the row twice, the second
// walk fetching the waiter's txn id, and then commits
// one request is in flight at a time
// reset empties the table (all slots free, nothing granted, no links)
// a held response stays in the output register; the tracker still finishes the
// next walk but waits with the table update until the response is taken
`include "assert_macros.svh"

module address_hazard_transaction_tracker
    import ahtt_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int TXN_BITS  = TXN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ahtt_req_if.sink    i_req,
    ahtt_rsp_if.source  o_rsp
);

    // control
    t_state               r_state, n_state;
    logic                 r_launch, n_launch;
    logic                 r_pass2, n_pass2;
    t_idx                 r_sel, n_sel;

    // held request; r_slot keeps the named slot while r_sel moves to the waiter
    logic                 r_mode;
    logic [TXN_BITS-1:0]  r_txn;
    logic [ADDR_BITS-1:0] r_addr;
    logic [4:0]           r_slot;

    // walk results
    t_carry               r_first;
    logic                 r_nx_valid;
    logic [TXN_BITS-1:0]  r_nx_txn;

    // response register
    logic                 r_out_valid;
    logic [4:0]           r_alloc_slot;
    logic                 r_grant_valid;
    logic [4:0]           r_grant_slot;
    logic [TXN_BITS-1:0]  r_grant_txn;
    t_err                 r_err;

    // cell row
    t_carry               w_carry [CAPACITY+1];
    logic [TXN_BITS-1:0]  w_ctxn  [CAPACITY+1];
    logic [CAPACITY-1:0]  w_pulse;
    t_cell_upd            w_upd;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_end;
    logic                 w_relaunch;
    logic                 w_commit;
    t_carry               w_last;

    // decided response
    logic [4:0]           w_alloc_slot;
    logic                 w_grant_valid;
    logic [4:0]           w_grant_slot;
    logic [TXN_BITS-1:0]  w_grant_txn;
    t_err                 w_err;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // record entering the row: fresh every cycle, pulse marks the live walk
    assign w_carry[0] = '{pulse: r_launch, default: '0};
    assign w_ctxn[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ahtt_cell #(
            .IDX       (g),
            .ADDR_BITS (ADDR_BITS),
            .TXN_BITS  (TXN_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_addr      (r_addr),
            .i_txn       (r_txn),
            .i_sel       (r_sel),
            .i_upd       (w_upd),
            .i_carry     (w_carry[g]),
            .i_carry_txn (w_ctxn[g]),
            .o_carry     (w_carry[g+1]),
            .o_carry_txn (w_ctxn[g+1])
        );
        assign w_pulse[g] = w_carry[g+1].pulse;
    end

    assign w_last = w_carry[CAPACITY];
    assign w_end  = (r_state == ST_SCAN) && w_last.pulse;

    // released slot has a waiter: walk again to fetch the waiter's id
    assign w_relaunch = w_end && !r_pass2 && (r_mode == MODE_RELEASE)
                        && w_last.sel_valid && w_last.sel_granted && w_last.sel_has_succ;

    // next state and control
    always_comb begin
        n_state  = r_state;
        n_launch = 1'b0;
        n_pass2  = r_pass2;
        n_sel    = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state  = ST_SCAN;
                    n_launch = 1'b1;
                    n_pass2  = 1'b0;
                    n_sel    = t_idx'(i_req.slot);
                end
            end
            ST_SCAN: begin
                if (w_relaunch) begin
                    n_launch = 1'b1;
                    n_pass2  = 1'b1;
                    n_sel    = w_last.sel_succ;
                end else if (w_end) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_commit = (r_state == ST_COMMIT) && w_out_free;

    // decide the response and the table update from the walk results
    always_comb begin
        w_upd         = '0;
        w_alloc_slot  = '0;
        w_grant_valid = 1'b0;
        w_grant_slot  = '0;
        w_grant_txn   = '0;
        w_err         = ERR_OK;
        if (r_mode == MODE_ALLOC) begin
            if (!r_first.free_hit) begin
                w_err = ERR_FULL;
            end else begin
                w_upd.wr_en      = w_commit;
                w_upd.wr_idx     = r_first.free_idx;
                w_upd.wr_granted = !r_first.tail_hit;
                w_upd.link_en    = w_commit && r_first.tail_hit;
                w_upd.link_idx   = r_first.tail_idx;
                w_upd.link_succ  = r_first.free_idx;
                w_alloc_slot     = r_first.free_idx[4:0];
                if (!r_first.tail_hit) begin
                    w_grant_valid = 1'b1;
                    w_grant_slot  = r_first.free_idx[4:0];
                    w_grant_txn   = r_txn;
                end
            end
        end else begin
            if (!r_first.sel_valid) begin
                w_err = ERR_NOT_VALID;
            end else if (!r_first.sel_granted) begin
                w_err = ERR_NOT_GRANTED;
            end else begin
                w_upd.clr_en  = w_commit;
                w_upd.clr_idx = t_idx'(r_slot);
                if (r_first.sel_has_succ && r_nx_valid) begin
                    w_upd.grant_en  = w_commit;
                    w_upd.grant_idx = r_first.sel_succ;
                    w_grant_valid   = 1'b1;
                    w_grant_slot    = r_first.sel_succ[4:0];
                    w_grant_txn     = r_nx_txn;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_pass2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_pass2  <= n_pass2;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        if (w_in_acc) begin
            r_mode <= i_req.mode;
            r_txn  <= i_req.txn_id;
            r_addr <= i_req.address;
            r_slot <= i_req.slot;
        end
        if (w_end && !r_pass2) begin
            r_first <= w_last;
        end
        if (w_end && r_pass2) begin
            r_nx_valid <= w_last.sel_valid;
            r_nx_txn   <= w_ctxn[CAPACITY];
        end
        if (w_commit) begin
            r_alloc_slot  <= w_alloc_slot;
            r_grant_valid <= w_grant_valid;
            r_grant_slot  <= w_grant_slot;
            r_grant_txn   <= w_grant_txn;
            r_err         <= w_err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.alloc_slot   = r_alloc_slot;
    assign o_rsp.grant_valid  = r_grant_valid;
    assign o_rsp.grant_slot   = r_grant_slot;
    assign o_rsp.grant_txn_id = r_grant_txn;
    assign o_rsp.error_code   = r_err;

    `AHTT_ASSERT_IMPL(a_one_walk, i_clk, i_rst_n, 1'b1, $onehot0(w_pulse), "two walks in the cell row")
    `AHTT_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n, w_in_acc, r_launch && r_state == ST_SCAN, "walk not started after accept")
    `AHTT_ASSERT_NEXT(a_commit_waits, i_clk, i_rst_n, r_state == ST_COMMIT && !w_out_free, r_state == ST_COMMIT, "table updated while response held")
    `AHTT_ASSERT_IMPL(a_no_self_grant, i_clk, i_rst_n, w_upd.clr_en && w_upd.grant_en, w_upd.grant_idx != w_upd.clr_idx, "release grants its own slot")

endmodule

// File: dv/address_hazard_transaction_tracker_test.sv
module address_hazard_transaction_tracker_test;
    import ahtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS    = 430;
    // long receiver hold-off, enough for the tracker to back up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // worst case request-to-response time is a double row walk
    localparam int DRAIN_CYCLES    = 2 * TABLE_SLOTS + 16;
    localparam int POOL_SIZE       = 4;

    // one expected or observed response transaction
    typedef struct packed {
        logic [4:0]  alloc_slot;
        logic        grant_valid;
        logic [4:0]  grant_slot;
        logic [15:0] grant_txn_id;
        t_err        error_code;
    } t_tracker_rsp;

    // shadow of the slot table plus the queue of responses still owed
    class hazard_scoreboard;
        bit              live      [TABLE_SLOTS];
        bit              granted   [TABLE_SLOTS];
        bit              linked    [TABLE_SLOTS];
        int              next_slot [TABLE_SLOTS];
        logic [15:0]     txn_tab   [TABLE_SLOTS];
        logic [47:0]     addr_tab  [TABLE_SLOTS];
        t_tracker_rsp    awaited_rsp[$];
        int              mismatches;

        function void clear_table();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                live[i]    = 1'b0;
                granted[i] = 1'b0;
                linked[i]  = 1'b0;
            end
            awaited_rsp.delete();
            mismatches = 0;
        endfunction

        // apply one request to the shadow table and return its response
        function t_tracker_rsp resolve_request(logic mode, logic [15:0] txn,
                                               logic [47:0] addr, logic [4:0] slot);
            t_tracker_rsp rsp;
            int           free_idx;
            int           tail_idx;
            int           nx;
            rsp        = '0;
            free_idx   = -1;
            tail_idx   = -1;
            if (mode == MODE_ALLOC) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!live[i]) begin
                        if (free_idx < 0) free_idx = i;
                    end else if (addr_tab[i] == addr && !linked[i] && tail_idx < 0) begin
                        tail_idx = i;
                    end
                end
                if (free_idx < 0) begin
                    rsp.error_code = ERR_FULL;
                end else begin
                    live[free_idx]     = 1'b1;
                    txn_tab[free_idx]  = txn;
                    addr_tab[free_idx] = addr;
                    linked[free_idx]   = 1'b0;
                    rsp.alloc_slot     = free_idx[4:0];
                    if (tail_idx < 0) begin
                        granted[free_idx]  = 1'b1;
                        rsp.grant_valid    = 1'b1;
                        rsp.grant_slot     = free_idx[4:0];
                        rsp.grant_txn_id   = txn;
                    end else begin
                        granted[free_idx]   = 1'b0;
                        linked[tail_idx]    = 1'b1;
                        next_slot[tail_idx] = free_idx;
                    end
                end
            end else begin
                if (!live[slot]) begin
                    rsp.error_code = ERR_NOT_VALID;
                end else if (!granted[slot]) begin
                    rsp.error_code = ERR_NOT_GRANTED;
                end else begin
                    if (linked[slot]) begin
                        nx = next_slot[slot];
                        if (live[nx]) begin
                            granted[nx]      = 1'b1;
                            rsp.grant_valid  = 1'b1;
                            rsp.grant_slot   = nx[4:0];
                            rsp.grant_txn_id = txn_tab[nx];
                        end
                    end
                    live[slot]    = 1'b0;
                    granted[slot] = 1'b0;
                    linked[slot]  = 1'b0;
                end
            end
            return rsp;
        endfunction

        function void note_request(logic mode, logic [15:0] txn,
                                    logic [47:0] addr, logic [4:0] slot);
            awaited_rsp.push_back(resolve_request(mode, txn, addr, slot));
        endfunction

        function void compare_field(string field, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_response(t_tracker_rsp got);
            t_tracker_rsp want;
            if (awaited_rsp.size() == 0) begin
                mismatches++;
                $display("%0t unexpected response: expected none actual %h", $time, got);
                return;
            end
            want = awaited_rsp.pop_front();
            compare_field("alloc_slot", 48'(want.alloc_slot), 48'(got.alloc_slot));
            compare_field("grant_valid", 48'(want.grant_valid), 48'(got.grant_valid));
            compare_field("grant_slot", 48'(want.grant_slot), 48'(got.grant_slot));
            compare_field("grant_txn_id", 48'(want.grant_txn_id), 48'(got.grant_txn_id));
            compare_field("error_code", 48'(want.error_code), 48'(got.error_code));
        endfunction

        // random granted slot, or -1 when nothing is granted
        function int pick_granted();
            int cands[$];
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (live[i] && granted[i]) cands.push_back(i);
            end
            if (cands.size() == 0) return -1;
            return cands[$urandom_range(cands.size() - 1)];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ahtt_req_if #(.ADDR_BITS(ADDR_BITS_DEF), .TXN_BITS(TXN_BITS_DEF)) req_if ();
    ahtt_rsp_if #(.TXN_BITS(TXN_BITS_DEF)) rsp_if ();

    address_hazard_transaction_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    hazard_scoreboard sb;

    // idle percentages for the current phase
    int          send_idle_pct;
    int          recv_stall_pct;
    // set once by the stimulus to start the long receiver hold-off
    logic        hold_off_armed;
    // small set of addresses so that same-address chains build up
    logic [47:0] addr_pool [POOL_SIZE];

    // 2 ns clock
    always begin
        #1ns i_clk = 1'b1;
        #1ns i_clk = 1'b0;
    end

    // watch both channels; responses are checked before the new request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_response('{alloc_slot:   rsp_if.alloc_slot,
                                    grant_valid:  rsp_if.grant_valid,
                                    grant_slot:   rsp_if.grant_slot,
                                    grant_txn_id: rsp_if.grant_txn_id,
                                    error_code:   t_err'(rsp_if.error_code)});
            end
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.mode, req_if.txn_id, req_if.address, req_if.slot);
            end
        end
    end

    // response ready: random stalls, plus one long hold-off counted here
    initial begin : rsp_ready_drive
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [47:0] random_address();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    // phases: no idling, sender idle, receiver stalling, both a little
    function automatic void set_idle_phase(int phase);
        case (phase)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 59;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 59;
            end
            default: begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
        endcase
    endfunction

    // offer one request transaction, with random idle cycles ahead of it
    task automatic push_request(input logic mode, input logic [15:0] txn,
                                input logic [47:0] addr, input logic [4:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.txn_id  <= txn;
        req_if.address <= addr;
        req_if.slot    <= slot;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // unused fields carry random values so every bit toggles
    task automatic alloc_req(input logic [15:0] txn, input logic [47:0] addr);
        push_request(MODE_ALLOC, txn, addr, 5'($urandom_range(31)));
    endtask

    task automatic release_req(input logic [4:0] slot);
        push_request(MODE_RELEASE, 16'($urandom()), random_address(), slot);
    endtask

    task automatic run_directed();
        release_req(5'd0);                      // release on empty table
        alloc_req(16'h0000, 48'h0);             // granted at once
        alloc_req(16'hffff, 48'h0);             // waits behind slot 0
        alloc_req(16'h1234, 48'hffff_ffff_ffff);
        alloc_req(16'h0005, 48'h0);             // chain of three on address zero
        release_req(5'd1);                      // not granted yet
        release_req(5'd0);                      // hands over to slot 1
        alloc_req(16'h0007, 48'h0);             // reuses slot 0, joins chain tail
        release_req(5'd1);                      // hands over to slot 3
        release_req(5'd31);                     // top slot, free
        alloc_req(16'h1234, 48'hffff_ffff_ffff); // repeated id, waits behind slot 2
        release_req(5'd2);                      // hands over to slot 1
        release_req(5'd2);                      // already freed
        release_req(5'd3);                      // hands over to slot 0
        release_req(5'd0);
        release_req(5'd1);
        alloc_req(16'h8000, 48'h8000_0000_0000);
        alloc_req(16'h7fff, 48'h7fff_ffff_ffff);
        release_req(5'd0);
        release_req(5'd1);
    endtask

    task automatic random_alloc();
        logic [47:0] addr;
        if ($urandom_range(99) < 70) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else addr = random_address();
        alloc_req(16'($urandom()), addr);
    endtask

    // mostly well-formed releases of granted slots, some stray ones
    task automatic random_release();
        int pick;
        pick = sb.pick_granted();
        if (pick >= 0 && $urandom_range(99) < 80) release_req(pick[4:0]);
        else release_req(5'($urandom_range(31)));
    endtask

    task automatic run_random();
        int fill_left;
        int drain_left;
        fill_left  = 0;
        drain_left = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) begin
                for (int p = 0; p < POOL_SIZE; p++) addr_pool[p] = random_address();
            end
            set_idle_phase((k / 60) % 4);
            // fill past capacity so the full-table case shows up
            if (k == 0 || k == 250) fill_left = TABLE_SLOTS + 2;
            // release bursts walk the chains down
            if (k == 100 || k == 330) drain_left = 40;
            if (k == 200) hold_off_armed <= 1'b1;
            if (fill_left > 0) begin
                fill_left--;
                random_alloc();
            end else if (drain_left > 0) begin
                drain_left--;
                random_release();
            end else if ($urandom_range(1)) begin
                random_alloc();
            end else begin
                random_release();
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        sb.clear_table();
        i_rst_n        = 1'b0;
        hold_off_armed = 1'b0;
        req_if.valid   = 1'b0;
        req_if.mode    = MODE_ALLOC;
        req_if.txn_id  = '0;
        req_if.address = '0;
        req_if.slot    = '0;
        set_idle_phase(0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        req_if.valid <= 1'b0;
        recv_stall_pct = 0;
        // wait for every owed response, then let any late extras show up
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("address_hazard_transaction_tracker verification clean");
        end else begin
            $display("address_hazard_transaction_tracker verification failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #800us;
        $display("address_hazard_transaction_tracker verification failed");
        $finish;
    end

endmodule
